// File: sv/fphc_pkg.sv
// Shared types and constants for the fan PWM hysteresis controller.
// No dependencies; imported by every module of the block.
package fphc_pkg;

    localparam int DUTY_BITS = 16;
    localparam int TEMP_BITS = 18;
    localparam int TEMP_W    = TEMP_BITS + 1;
    localparam int DIFF_W    = TEMP_W + 1;
    localparam int REM_W     = TEMP_W + 1;
    localparam int STEPS     = 2 * DUTY_BITS;
    localparam int CNT_W     = $clog2(STEPS);
    localparam int IDX_W     = $clog2(DUTY_BITS);
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    localparam logic [2:0] REG_TEMP_ON        = 3'd0;
    localparam logic [2:0] REG_TEMP_OFF       = 3'd1;
    localparam logic [2:0] REG_TEMP_HIGH      = 3'd2;
    localparam logic [2:0] REG_PWM_FULL_SCALE = 3'd3;
    localparam logic [2:0] REG_MIN_LEVEL      = 3'd4;
    localparam logic [2:0] REG_RISE_DEADBAND  = 3'd5;
    localparam logic [2:0] REG_FALL_DEADBAND  = 3'd6;

    localparam logic signed [TEMP_W-1:0] RST_TEMP_ON        = TEMP_W'(55000);
    localparam logic signed [TEMP_W-1:0] RST_TEMP_OFF       = TEMP_W'(45000);
    localparam logic signed [TEMP_W-1:0] RST_TEMP_HIGH      = TEMP_W'(70000);
    localparam logic [DUTY_BITS-1:0]     RST_PWM_FULL_SCALE = DUTY_BITS'(1024);
    localparam logic [DUTY_BITS-1:0]     RST_MIN_LEVEL      = DUTY_BITS'(307);
    localparam logic [DUTY_BITS-1:0]     RST_RISE_DEADBAND  = DUTY_BITS'(40);
    localparam logic [DUTY_BITS-1:0]     RST_FALL_DEADBAND  = DUTY_BITS'(71);

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_on;
        logic signed [TEMP_W-1:0] temp_off;
        logic signed [TEMP_W-1:0] temp_high;
        logic [DUTY_BITS-1:0]     pwm_full_scale;
        logic [DUTY_BITS-1:0]     min_level;
        logic [DUTY_BITS-1:0]     rise_deadband;
        logic [DUTY_BITS-1:0]     fall_deadband;
    } cfg_t;

    typedef struct packed {
        logic             load;
        logic             prep;
        logic             step;
        logic             phase;
        logic [IDX_W-1:0] bit_idx;
        logic             finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

// File: sv/fphc_regs.sv
// APB-style configuration registers of the fan PWM controller.
// Depends on fphc_pkg for register codes, reset values and cfg_t.
module fphc_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fphc_pkg::ADDR_W-1:0]   paddr,
    input  logic [fphc_pkg::DATA_W-1:0]   pwdata,
    output logic [fphc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output fphc_pkg::cfg_t                cfg
);
    import fphc_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] idx;
    logic       wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.temp_on        <= RST_TEMP_ON;
            cfg_reg.temp_off       <= RST_TEMP_OFF;
            cfg_reg.temp_high      <= RST_TEMP_HIGH;
            cfg_reg.pwm_full_scale <= RST_PWM_FULL_SCALE;
            cfg_reg.min_level      <= RST_MIN_LEVEL;
            cfg_reg.rise_deadband  <= RST_RISE_DEADBAND;
            cfg_reg.fall_deadband  <= RST_FALL_DEADBAND;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_TEMP_ON:        cfg_reg.temp_on        <= pwdata[TEMP_W-1:0];
                REG_TEMP_OFF:       cfg_reg.temp_off       <= pwdata[TEMP_W-1:0];
                REG_TEMP_HIGH:      cfg_reg.temp_high      <= pwdata[TEMP_W-1:0];
                REG_PWM_FULL_SCALE: cfg_reg.pwm_full_scale <= pwdata[DUTY_BITS-1:0];
                REG_MIN_LEVEL:      cfg_reg.min_level      <= pwdata[DUTY_BITS-1:0];
                REG_RISE_DEADBAND:  cfg_reg.rise_deadband  <= pwdata[DUTY_BITS-1:0];
                REG_FALL_DEADBAND:  cfg_reg.fall_deadband  <= pwdata[DUTY_BITS-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_TEMP_ON:        prdata = DATA_W'(unsigned'(cfg_reg.temp_on));
            REG_TEMP_OFF:       prdata = DATA_W'(unsigned'(cfg_reg.temp_off));
            REG_TEMP_HIGH:      prdata = DATA_W'(unsigned'(cfg_reg.temp_high));
            REG_PWM_FULL_SCALE: prdata = DATA_W'(cfg_reg.pwm_full_scale);
            REG_MIN_LEVEL:      prdata = DATA_W'(cfg_reg.min_level);
            REG_RISE_DEADBAND:  prdata = DATA_W'(cfg_reg.rise_deadband);
            REG_FALL_DEADBAND:  prdata = DATA_W'(cfg_reg.fall_deadband);
            default:            prdata = '0;
        endcase
    end

endmodule

// File: sv/fphc_ctrl.sv
// Sequencer of the fan PWM controller: load, prepare, divide, finish.
// Depends on fphc_pkg for the command and status structs.
module fphc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  fphc_pkg::dp_status_t status,
    output fphc_pkg::ctrl_cmd_t  cmd
);
    import fphc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd.load    = 1'b0;
        cmd.prep    = 1'b0;
        cmd.step    = 1'b0;
        cmd.phase   = cnt_reg[0];
        // walk the duty weight from its top bit down
        cmd.bit_idx = IDX_W'(DUTY_BITS - 1) - cnt_reg[CNT_W-1:1];
        cmd.finish  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1))
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: sv/fphc_dpath.sv
// Datapath of the fan PWM controller: threshold tests, serial scale-divide,
// deadband decision, fan state and the result register. Depends on fphc_pkg.
module fphc_dpath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  fphc_pkg::cfg_t                     cfg,
    input  fphc_pkg::ctrl_cmd_t                cmd,
    output fphc_pkg::dp_status_t               status,
    input  logic signed [fphc_pkg::TEMP_W-1:0] temp_mdeg,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [fphc_pkg::DUTY_BITS-1:0]     duty,
    output logic                               fan_running,
    output logic                               duty_written,
    output logic                               start_pulse,
    output logic                               config_fault
);
    import fphc_pkg::*;

    // item operands
    logic signed [TEMP_W-1:0] temp_reg;
    logic [TEMP_W-1:0]        a_reg;     // clamped temperature offset
    logic [TEMP_W-1:0]        c_reg;     // temperature span
    logic [DUTY_BITS-1:0]     w_reg;     // full scale minus minimum
    logic [DUTY_BITS-1:0]     m_reg;
    logic                     fault_reg;
    logic                     next_on_reg;
    logic [REM_W-1:0]         r_reg;
    logic [DUTY_BITS-1:0]     q_reg;

    // persistent state
    logic                 fan_on_reg;
    logic [DUTY_BITS-1:0] applied_reg;

    // result register
    logic                 out_valid_reg;
    logic [DUTY_BITS-1:0] duty_reg;
    logic                 fan_out_reg, written_reg, pulse_reg, fault_out_reg;

    // prepare cycle
    logic signed [DIFF_W-1:0] diff, span;
    logic [DUTY_BITS-1:0]     m_sat;
    logic [TEMP_W-1:0]        a_clamp;
    logic                     above_on, below_off, next_on;

    always_comb
    begin
        diff      = DIFF_W'(temp_reg) - DIFF_W'(cfg.temp_off);
        span      = DIFF_W'(cfg.temp_high) - DIFF_W'(cfg.temp_off);
        above_on  = temp_reg > cfg.temp_on;
        below_off = temp_reg < cfg.temp_off;
        next_on   = above_on ? 1'b1 : (below_off ? 1'b0 : fan_on_reg);
        m_sat     = (cfg.min_level > cfg.pwm_full_scale) ? cfg.pwm_full_scale
                                                         : cfg.min_level;
        priority if (diff < 0)
            a_clamp = '0;
        else if (diff > span)
            a_clamp = span[TEMP_W-1:0];
        else
            a_clamp = diff[TEMP_W-1:0];
    end

    // one divide step: shift-and-reduce, or conditional add-and-reduce
    logic [REM_W-1:0]     r_pre, r_red;
    logic                 r_ge;
    logic [DUTY_BITS-1:0] q_pre;

    always_comb
    begin
        if (!cmd.phase)
        begin
            r_pre = {r_reg[REM_W-2:0], 1'b0};
            q_pre = {q_reg[DUTY_BITS-2:0], 1'b0};
        end
        else
        begin
            r_pre = w_reg[cmd.bit_idx] ? (r_reg + REM_W'(a_reg)) : r_reg;
            q_pre = q_reg;
        end
        r_ge  = r_pre >= REM_W'(c_reg);
        r_red = r_ge ? (r_pre - REM_W'(c_reg)) : r_pre;
    end

    // finish: deadband decision and state update
    logic [DUTY_BITS-1:0] level, delta, need, new_applied;
    logic                 new_fan, new_written, new_pulse;

    always_comb
    begin
        level       = m_reg + q_reg;
        new_applied = applied_reg;
        new_fan     = fan_on_reg;
        new_written = 1'b0;
        new_pulse   = 1'b0;
        if (level > applied_reg)
        begin
            delta = level - applied_reg;
            need  = cfg.rise_deadband;
        end
        else
        begin
            delta = applied_reg - level;
            need  = cfg.fall_deadband;
        end
        if (!fault_reg && (next_on_reg || fan_on_reg))
        begin
            if (next_on_reg == fan_on_reg)
            begin
                if (delta >= need)
                begin
                    new_applied = level;
                    new_written = 1'b1;
                end
            end
            else
            begin
                new_pulse   = next_on_reg;
                new_applied = next_on_reg ? level : '0;
                new_written = 1'b1;
                new_fan     = next_on_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            temp_reg <= temp_mdeg;
        if (cmd.prep)
        begin
            a_reg       <= a_clamp;
            c_reg       <= span[TEMP_W-1:0];
            m_reg       <= m_sat;
            w_reg       <= cfg.pwm_full_scale - m_sat;
            fault_reg   <= !(span > 0);
            next_on_reg <= next_on;
            r_reg       <= '0;
            q_reg       <= '0;
        end
        if (cmd.step)
        begin
            r_reg <= r_red;
            q_reg <= q_pre + DUTY_BITS'(r_ge);
        end
        if (cmd.finish)
        begin
            duty_reg      <= new_applied;
            fan_out_reg   <= new_fan;
            written_reg   <= new_written;
            pulse_reg     <= new_pulse;
            fault_out_reg <= fault_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fan_on_reg    <= 1'b0;
            applied_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                fan_on_reg    <= new_fan;
                applied_reg   <= new_applied;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign duty            = duty_reg;
    assign fan_running     = fan_out_reg;
    assign duty_written    = written_reg;
    assign start_pulse     = pulse_reg;
    assign config_fault    = fault_out_reg;

endmodule

// File: sv/fan_pwm_hysteresis_controller.sv
// Top level of the fan PWM hysteresis controller.
// Depends on fphc_pkg, fphc_regs, fphc_ctrl and fphc_dpath.
//
// Each temperature item yields one result item. An item runs through a load
// step, a step for the threshold tests and clamping, the shift-subtract unit
// that forms floor(offset * (full - min) / span) two steps per duty bit, and
// a finish step that applies the deadband and loads the result register
// once it is free; no new item is accepted before that. A finished result
// waits in that register while the next item is taken. The user must write
// configuration over the APB port only while idle; nothing enforces this.
module fan_pwm_hysteresis_controller (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fphc_pkg::ADDR_W-1:0]         paddr,
    input  logic [fphc_pkg::DATA_W-1:0]         pwdata,
    output logic [fphc_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [fphc_pkg::TEMP_W-1:0]  temp_mdeg,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [fphc_pkg::DUTY_BITS-1:0]      duty,
    output logic                                fan_running,
    output logic                                duty_written,
    output logic                                start_pulse,
    output logic                                config_fault
);
    import fphc_pkg::*;

    cfg_t       cfg;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    fphc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fphc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    fphc_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .status       (status),
        .temp_mdeg    (temp_mdeg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .duty         (duty),
        .fan_running  (fan_running),
        .duty_written (duty_written),
        .start_pulse  (start_pulse),
        .config_fault (config_fault)
    );

endmodule
